### hw/rtl/psg_pkg.sv
package psg_pkg;

  typedef logic signed [12:0] timer_t;
  typedef logic [11:0]        period_t;
  typedef logic [12:0]        sample_t;

  // Result of one timer update.
  typedef struct packed {
    timer_t timer;
    logic   sq;
    logic   fired;
  } sq_upd_t;

  localparam logic [3:0] REG_TONE_FINE_A   = 4'd0;
  localparam logic [3:0] REG_TONE_COARSE_A = 4'd1;
  localparam logic [3:0] REG_TONE_FINE_B   = 4'd2;
  localparam logic [3:0] REG_TONE_COARSE_B = 4'd3;
  localparam logic [3:0] REG_TONE_FINE_C   = 4'd4;
  localparam logic [3:0] REG_TONE_COARSE_C = 4'd5;
  localparam logic [3:0] REG_NOISE_PERIOD  = 4'd6;
  localparam logic [3:0] REG_MIXER         = 4'd7;
  localparam logic [3:0] REG_LEVEL_A       = 4'd8;
  localparam logic [3:0] REG_LEVEL_B       = 4'd9;
  localparam logic [3:0] REG_LEVEL_C       = 4'd10;
  localparam logic [3:0] REG_ENV_FINE      = 4'd11;
  localparam logic [3:0] REG_ENV_COARSE    = 4'd12;
  localparam logic [3:0] REG_ENV_SHAPE     = 4'd13;

  localparam logic       ACT_WRITE       = 1'b0;
  localparam logic       ACT_TICK        = 1'b1;
  localparam logic [7:0] TICK_STEP_RESET = 8'd5;
  localparam logic [15:0] LFSR_SEED      = 16'h8000;
  localparam logic [4:0] ENV_LAST_STEP   = 5'd31;

  // Subtract the step; on run-out add the period and toggle the square, unless the period is zero or below the step.
  function automatic sq_upd_t run_timer(timer_t timer, period_t period,
                                        logic [7:0] st, logic sq);
    logic signed [13:0] diff;
    logic signed [13:0] rel;
    sq_upd_t            r;
    diff    = $signed({timer[12], timer}) - $signed({6'b0, st});
    rel     = diff + $signed({2'b0, period});
    r.timer = diff[12:0];
    r.sq    = sq;
    r.fired = 1'b0;
    if (diff <= 14'sd0) begin
      if (period == '0) begin
        r.sq    = 1'b1;
        r.timer = '0;
      end else if ({4'b0, st} > period) begin
        r.timer = $signed({1'b0, period});
      end else begin
        r.timer = rel[12:0];
        r.sq    = ~sq;
        r.fired = 1'b1;
      end
    end
    return r;
  endfunction

  // Envelope level for a shape and a step of the 32-step cycle.
  function automatic logic [3:0] env_level(logic [3:0] shape, logic [4:0] stp);
    logic [3:0] j;
    logic [3:0] lvl;
    j = stp[3:0];
    if (!stp[4]) begin
      lvl = shape[2] ? j : ~j;
    end else if (!shape[3]) begin
      lvl = 4'd0;
    end else begin
      case (shape[2:0])
        3'd0:    lvl = ~j;
        3'd1:    lvl = 4'd0;
        3'd2:    lvl = j;
        3'd3:    lvl = 4'd15;
        3'd4:    lvl = j;
        3'd5:    lvl = 4'd15;
        3'd6:    lvl = ~j;
        default: lvl = 4'd0;
      endcase
    end
    return lvl;
  endfunction

  function automatic logic [11:0] level_lut(logic [3:0] lvl);
    logic [11:0] v;
    case (lvl)
      4'd0:    v = 12'd0;
      4'd1:    v = 12'd100;
      4'd2:    v = 12'd130;
      4'd3:    v = 12'd160;
      4'd4:    v = 12'd200;
      4'd5:    v = 12'd250;
      4'd6:    v = 12'd320;
      4'd7:    v = 12'd400;
      4'd8:    v = 12'd510;
      4'd9:    v = 12'd640;
      4'd10:   v = 12'd800;
      4'd11:   v = 12'd1010;
      4'd12:   v = 12'd1280;
      4'd13:   v = 12'd1610;
      4'd14:   v = 12'd2020;
      default: v = 12'd2550;
    endcase
    return v;
  endfunction

endpackage

### hw/rtl/psg_three_voice_sound_generator.sv
// Three-voice sound generator, one audio sample per tick.
//
// Input channel (in_valid/in_ready): each transfer is either a write of
// in_reg_value to sound register in_reg_addr (in_action = 0, no result) or
// a tick (in_action = 1) that advances the tone, noise and envelope timers
// by cfg_wdata-programmed tick_step and yields one sample.
// Output channel (out_valid/out_ready): out_sample is the sum of the three
// gated voice levels, 0..7650.
// Config port: cfg_we loads cfg_wdata into tick_step at the next edge.
//
// Latency: the sample of a tick is on out_sample the cycle after the tick
// is accepted. Throughput: one item per cycle; the only storage between
// input and output is the single output register, so in_ready follows
// out_ready while a sample is held.
// Receiver stall: the sample is held and in_ready drops until it is taken.
// Reset (rst_n low, synchronous): all sound registers and timers clear,
// squares go high, the noise LFSR reloads 0x8000, tick_step becomes 5,
// and the output register empties.
module psg_three_voice_sound_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [3:0]  in_reg_addr,
  input  logic [7:0]  in_reg_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [12:0] out_sample,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);
  import psg_pkg::*;

  // Sound registers
  logic [7:0]  tick_step_r;
  period_t     tone_period_r [3];
  period_t     tone_period_nxt [3];
  logic [7:0]  noise_period_r, noise_period_nxt;
  logic [2:0]  tone_en_r, tone_en_nxt;
  logic [2:0]  noise_en_r, noise_en_nxt;
  logic [3:0]  level_r [3];
  logic [3:0]  level_nxt [3];
  logic [2:0]  use_env_r, use_env_nxt;
  logic [15:0] env_raw_r, env_raw_nxt;
  logic [3:0]  env_shape_r, env_shape_nxt;

  // Generator state; index 3 is the noise timer.
  timer_t      timer_r [4];
  timer_t      timer_nxt [4];
  logic [3:0]  sq_r, sq_nxt;
  logic [15:0] lfsr_r, lfsr_nxt;
  timer_t      env_timer_r, env_timer_nxt;
  logic [4:0]  env_step_r, env_step_nxt;

  logic        out_valid_r, out_valid_nxt;
  sample_t     out_sample_r, out_sample_nxt;

  // Post-tick values, used both for the state and for the sample.
  sq_upd_t     upd [4];
  sq_upd_t     env_upd;
  logic [15:0] lfsr_tick;
  logic [4:0]  step_tick;
  logic [3:0]  env_lvl;
  logic [11:0] voice_amp [3];

  logic        accept;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // Tick datapath
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      upd[i] = run_timer(timer_r[i], tone_period_r[i], tick_step_r, sq_r[i]);
    end
    upd[3]  = run_timer(timer_r[3], {4'b0, noise_period_r}, tick_step_r, sq_r[3]);
    env_upd = run_timer(env_timer_r, env_raw_r[15:4], tick_step_r, 1'b0);

    // Noise shifts when its square rises.
    lfsr_tick = lfsr_r;
    if (upd[3].fired && upd[3].sq) begin
      lfsr_tick = {lfsr_r[0] ^ lfsr_r[3], lfsr_r[15:1]};
    end

    step_tick = env_step_r;
    if (env_upd.fired) begin
      if (env_step_r == ENV_LAST_STEP) begin
        if (env_shape_r[3] && !env_shape_r[0]) begin
          step_tick = '0;
        end
      end else begin
        step_tick = env_step_r + 5'd1;
      end
    end

    env_lvl = env_level(env_shape_r, step_tick);
    for (int i = 0; i < 3; i++) begin
      if ((upd[i].sq && tone_en_r[i]) || (lfsr_tick[0] && noise_en_r[i])) begin
        voice_amp[i] = level_lut(use_env_r[i] ? env_lvl : level_r[i]);
      end else begin
        voice_amp[i] = '0;
      end
    end
    out_sample_nxt = {1'b0, voice_amp[0]} + {1'b0, voice_amp[1]}
                   + {1'b0, voice_amp[2]};
  end

  // Next state
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tone_period_nxt[i] = tone_period_r[i];
      level_nxt[i]       = level_r[i];
    end
    for (int i = 0; i < 4; i++) begin
      timer_nxt[i] = timer_r[i];
    end
    noise_period_nxt = noise_period_r;
    tone_en_nxt      = tone_en_r;
    noise_en_nxt     = noise_en_r;
    use_env_nxt      = use_env_r;
    env_raw_nxt      = env_raw_r;
    env_shape_nxt    = env_shape_r;
    sq_nxt           = sq_r;
    lfsr_nxt         = lfsr_r;
    env_timer_nxt    = env_timer_r;
    env_step_nxt     = env_step_r;
    out_valid_nxt    = out_valid_r && !out_ready;

    if (accept) begin
      if (in_action == ACT_TICK) begin
        for (int i = 0; i < 4; i++) begin
          timer_nxt[i] = upd[i].timer;
          sq_nxt[i]    = upd[i].sq;
        end
        lfsr_nxt      = lfsr_tick;
        env_timer_nxt = env_upd.timer;
        env_step_nxt  = step_tick;
        out_valid_nxt = 1'b1;
      end else begin
        case (in_reg_addr)
          REG_TONE_FINE_A, REG_TONE_FINE_B, REG_TONE_FINE_C: begin
            tone_period_nxt[in_reg_addr[2:1]][7:0] = in_reg_value;
          end
          REG_TONE_COARSE_A, REG_TONE_COARSE_B, REG_TONE_COARSE_C: begin
            tone_period_nxt[in_reg_addr[2:1]][11:8] = in_reg_value[3:0];
          end
          REG_NOISE_PERIOD: noise_period_nxt = in_reg_value;
          REG_MIXER: begin
            // Mixer bits are active-low enables.
            tone_en_nxt  = ~in_reg_value[2:0];
            noise_en_nxt = ~in_reg_value[5:3];
          end
          REG_LEVEL_A: begin
            level_nxt[0]   = in_reg_value[3:0];
            use_env_nxt[0] = in_reg_value[4];
          end
          REG_LEVEL_B: begin
            level_nxt[1]   = in_reg_value[3:0];
            use_env_nxt[1] = in_reg_value[4];
          end
          REG_LEVEL_C: begin
            level_nxt[2]   = in_reg_value[3:0];
            use_env_nxt[2] = in_reg_value[4];
          end
          REG_ENV_FINE:   env_raw_nxt[7:0]  = in_reg_value;
          REG_ENV_COARSE: env_raw_nxt[15:8] = in_reg_value;
          // Shape write does not restart the envelope.
          REG_ENV_SHAPE:  env_shape_nxt     = in_reg_value[3:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_step_r    <= TICK_STEP_RESET;
      for (int i = 0; i < 3; i++) begin
        tone_period_r[i] <= '0;
        level_r[i]       <= '0;
      end
      for (int i = 0; i < 4; i++) begin
        timer_r[i] <= '0;
      end
      noise_period_r <= '0;
      tone_en_r      <= '0;
      noise_en_r     <= '0;
      use_env_r      <= '0;
      env_raw_r      <= '0;
      env_shape_r    <= '0;
      sq_r           <= '1;
      lfsr_r         <= LFSR_SEED;
      env_timer_r    <= '0;
      env_step_r     <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        tick_step_r <= cfg_wdata;
      end
      for (int i = 0; i < 3; i++) begin
        tone_period_r[i] <= tone_period_nxt[i];
        level_r[i]       <= level_nxt[i];
      end
      for (int i = 0; i < 4; i++) begin
        timer_r[i] <= timer_nxt[i];
      end
      noise_period_r <= noise_period_nxt;
      tone_en_r      <= tone_en_nxt;
      noise_en_r     <= noise_en_nxt;
      use_env_r      <= use_env_nxt;
      env_raw_r      <= env_raw_nxt;
      env_shape_r    <= env_shape_nxt;
      sq_r           <= sq_nxt;
      lfsr_r         <= lfsr_nxt;
      env_timer_r    <= env_timer_nxt;
      env_step_r     <= env_step_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Sample payload, no reset.
  always_ff @(posedge clk) begin
    if (accept && (in_action == ACT_TICK)) begin
      out_sample_r <= out_sample_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

  // A tick always produces a sample in the next cycle.
  a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_action == ACT_TICK)) |=> out_valid_r)
    else $error("tick transfer left no sample");

  // A register write never produces a sample.
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_action == ACT_WRITE) && !(out_valid_r && !out_ready))
      |=> !out_valid_r)
    else $error("register write produced a sample");

  // The LFSR update is invertible, so it never reaches the all-zero lockup.
  a_lfsr_live: assert property (@(posedge clk) disable iff (!rst_n)
    lfsr_r != '0)
    else $error("noise LFSR locked at zero");

  // Reloads keep every timer non-negative between ticks.
  a_timer_sign: assert property (@(posedge clk) disable iff (!rst_n)
    !timer_r[0][12] && !timer_r[1][12] && !timer_r[2][12] && !timer_r[3][12]
      && !env_timer_r[12])
    else $error("period timer went negative");

  a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_sample_r <= 13'd7650))
    else $error("sample out of range");

endmodule
